// ===== hdl/cpot_pkg.sv =====
// Package for the convex polygon overlap test core.
// Holds the lane width constant and the vertex-count clamp.
// No dependencies.
package cpot_pkg;

	localparam int LANE_BITS = 16;

	// clamp a vertex count into three..max_v
	function automatic logic [2:0] clamp_count(input logic [2:0] cnt, input logic [2:0] max_v);
		logic [2:0] r;
		r = cnt;
		if (cnt < 3'd3)
			r = 3'd3;
		else if (cnt > max_v)
			r = max_v;
		return r;
	endfunction

endpackage

// ===== hdl/convex_polygon_overlap_test_core.sv =====
// Convex polygon overlap test core: separating-axis test on two polygons.
// Uses cpot_pkg and cpot_axis_unit (one per candidate edge normal).
//
// Usage:
//   Drive poly_a_* and poly_b_* with start high; the transaction is taken
//   at a rising edge where start is high and busy is low. busy is always
//   low, so one transaction can be taken every cycle.
//   done pulses for one cycle, with overlap valid in that cycle, after the
//   stage 0, product, interval, flag and OR registers; one test per cycle.
//   Stages: unpack and edge normals, dot products, projection intervals,
//   per-axis gap test, OR of all axes into the result.
//   Counts below three read as three, above MAX_VERTS as MAX_VERTS.
//   Reset clears all valid bits; no result is lost or invented.
//   The receiver cannot stall; results are shown once and must be taken.
module convex_polygon_overlap_test_core import cpot_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int MAX_VERTS  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] poly_a_x,
	input  logic [63:0] poly_a_y,
	input  logic [2:0]  poly_a_count,
	input  logic [63:0] poly_b_x,
	input  logic [63:0] poly_b_y,
	input  logic [2:0]  poly_b_count,
	output logic        done,
	output logic        overlap
);
	localparam int CB = COORD_BITS;
	localparam int NV = MAX_VERTS;
	localparam int NA = 2 * NV;

	logic signed [CB-1:0] xa_s0 [NV], ya_s0 [NV], xb_s0 [NV], yb_s0 [NV];
	logic [NV-1:0]        ua_s0, ub_s0;
	logic signed [CB:0]   ax_s0 [NA], ay_s0 [NA];
	logic [NA-1:0]        act_s0;
	logic [2:0]           na_c, nb_c;
	logic [NA-1:0]        sep_s3;
	logic [4:0]           vld_q;
	logic                 ovl_q;
	logic                 accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign na_c   = clamp_count(poly_a_count, 3'(NV));
	assign nb_c   = clamp_count(poly_b_count, 3'(NV));

	// stage 0: unpack lanes, form edge normals (-ey, ex)
	always_ff @(posedge clk) begin
		logic signed [CB-1:0] xa [NV], ya [NV], xb [NV], yb [NV];
		int j;
		for (int i = 0; i < NV; i++) begin
			xa[i] = poly_a_x[i*LANE_BITS +: CB];
			ya[i] = poly_a_y[i*LANE_BITS +: CB];
			xb[i] = poly_b_x[i*LANE_BITS +: CB];
			yb[i] = poly_b_y[i*LANE_BITS +: CB];
		end
		for (int i = 0; i < NV; i++) begin
			xa_s0[i] <= xa[i]; ya_s0[i] <= ya[i];
			xb_s0[i] <= xb[i]; yb_s0[i] <= yb[i];
			ua_s0[i] <= (3'(i) < na_c);
			ub_s0[i] <= (3'(i) < nb_c);
			j = (3'(i + 1) == na_c) ? 0 : (i + 1) % NV;
			ax_s0[i]  <= (CB+1)'(ya[i]) - (CB+1)'(ya[j]);
			ay_s0[i]  <= (CB+1)'(xa[j]) - (CB+1)'(xa[i]);
			act_s0[i] <= (3'(i) < na_c);
			j = (3'(i + 1) == nb_c) ? 0 : (i + 1) % NV;
			ax_s0[NV+i]  <= (CB+1)'(yb[i]) - (CB+1)'(yb[j]);
			ay_s0[NV+i]  <= (CB+1)'(xb[j]) - (CB+1)'(xb[i]);
			act_s0[NV+i] <= (3'(i) < nb_c);
		end
	end

	// one axis unit per candidate normal
	for (genvar g = 0; g < NA; g++) begin : g_axis
		cpot_axis_unit #(.CB(CB), .NV(NV)) u_axis (
			.clk(clk), .arst_n(arst_n), .en(1'b1),
			.ax(ax_s0[g]), .ay(ay_s0[g]),
			.xa(xa_s0), .ya(ya_s0), .xb(xb_s0), .yb(yb_s0),
			.use_a(ua_s0), .use_b(ub_s0), .act(act_s0[g]),
			.sep(sep_s3[g])
		);
	end

	// valid line and final reduction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[3:0], accept};
	end

	always_ff @(posedge clk)
		ovl_q <= ~|sep_s3;

	assign done    = vld_q[4];
	assign overlap = ovl_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done) else $error("done did not follow accept");
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5)) else $error("done without transaction");
	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
endmodule

// ===== hdl/cpot_axis_unit.sv =====
// One separating-axis lane: dot products, interval min/max, separation flag.
// Depends on cpot_pkg. Three register stages (products, intervals, flag).
module cpot_axis_unit import cpot_pkg::*; #(
	parameter int CB = 16,
	parameter int NV = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic signed [CB:0]    ax,
	input  logic signed [CB:0]    ay,
	input  logic signed [CB-1:0]  xa [NV],
	input  logic signed [CB-1:0]  ya [NV],
	input  logic signed [CB-1:0]  xb [NV],
	input  logic signed [CB-1:0]  yb [NV],
	input  logic [NV-1:0]         use_a,
	input  logic [NV-1:0]         use_b,
	input  logic                  act,
	output logic                  sep
);
	localparam int PW = 2 * CB + 2;

	logic signed [PW-1:0] da_s1 [NV];
	logic signed [PW-1:0] db_s1 [NV];
	logic [NV-1:0]        ua_s1, ub_s1;
	logic                 act_s1;
	logic signed [PW-1:0] mna_s2, mxa_s2, mnb_s2, mxb_s2;
	logic                 act_s2;
	logic signed [PW-1:0] mna, mxa, mnb, mxb;

	// stage 1: dot products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NV; i++) begin
				da_s1[i] <= PW'(ax * xa[i]) + PW'(ay * ya[i]);
				db_s1[i] <= PW'(ax * xb[i]) + PW'(ay * yb[i]);
			end
			ua_s1  <= use_a;
			ub_s1  <= use_b;
			act_s1 <= act;
		end
	end

	// stage 2: projection intervals (vertex 0 always used)
	always_comb begin
		mna = da_s1[0]; mxa = da_s1[0];
		mnb = db_s1[0]; mxb = db_s1[0];
		for (int i = 1; i < NV; i++) begin
			if (ua_s1[i] && da_s1[i] < mna) mna = da_s1[i];
			if (ua_s1[i] && da_s1[i] > mxa) mxa = da_s1[i];
			if (ub_s1[i] && db_s1[i] < mnb) mnb = db_s1[i];
			if (ub_s1[i] && db_s1[i] > mxb) mxb = db_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mna_s2 <= mna; mxa_s2 <= mxa;
			mnb_s2 <= mnb; mxb_s2 <= mxb;
			act_s2 <= act_s1;
		end
	end

	// stage 3: interval gap test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sep <= 1'b0;
		else if (en)
			sep <= act_s2 && (mxa_s2 < mnb_s2 || mxb_s2 < mna_s2);
	end
endmodule

// ===== tb/convex_polygon_overlap_test_core_test.sv =====
// Testbench for convex_polygon_overlap_test_core: random and directed polygon pairs,
// separating-axis predictor, in-order check of overlap on each done strobe.
// Depends on cpot_pkg and convex_polygon_overlap_test_core.
module convex_polygon_overlap_test_core_test import cpot_pkg::*;;

	localparam int CB = 16;
	localparam int MV = 4;
	localparam int LATENCY = 5;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic [63:0] ax, ay, bx, by;
		logic [2:0]  ac, bc;
		logic        hold; // wait for all results before this one
	} poly_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [63:0] poly_a_x = '0, poly_a_y = '0, poly_b_x = '0, poly_b_y = '0;
	logic [2:0]  poly_a_count = 3'd3, poly_b_count = 3'd3;
	logic        done;
	logic        overlap;

	poly_pair_t pending_pairs[$];
	logic       overlap_expected[$];
	int         failures = 0;
	int         quiet_cycles = 0;
	bit         stimulus_done = 1'b0;

	convex_polygon_overlap_test_core #(.COORD_BITS(CB), .MAX_VERTS(MV)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.poly_a_x(poly_a_x), .poly_a_y(poly_a_y), .poly_a_count(poly_a_count),
		.poly_b_x(poly_b_x), .poly_b_y(poly_b_y), .poly_b_count(poly_b_count),
		.done(done), .overlap(overlap)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// signed coordinate from the low CB bits of a lane
	function automatic longint coord(logic [63:0] w, int i);
		logic [15:0] lane;
		lane = w[i*LANE_BITS +: 16];
		return longint'(signed'(lane[CB-1:0]));
	endfunction

	function automatic int eff_count(logic [2:0] c);
		if (c < 3'd3) return 3;
		if (int'(c) > MV) return MV;
		return int'(c);
	endfunction

	// projection interval of one polygon onto axis (nx, ny)
	function automatic void proj(logic [63:0] xs, logic [63:0] ys, int n, longint nx,
			longint ny, output longint lo, output longint hi);
		longint d;
		lo = nx * coord(xs, 0) + ny * coord(ys, 0);
		hi = lo;
		for (int i = 1; i < n; i++) begin
			d = nx * coord(xs, i) + ny * coord(ys, i);
			if (d < lo) lo = d;
			if (d > hi) hi = d;
		end
	endfunction

	// true if an edge normal of the source polygon separates the pair
	function automatic bit edge_separates(poly_pair_t p, bit from_b);
		logic [63:0] sx, sy;
		int sn, na, nb, j;
		longint ex, ey, alo, ahi, blo, bhi;
		sx = from_b ? p.bx : p.ax;
		sy = from_b ? p.by : p.ay;
		sn = eff_count(from_b ? p.bc : p.ac);
		na = eff_count(p.ac);
		nb = eff_count(p.bc);
		for (int i = 0; i < sn; i++) begin
			j = (i + 1 == sn) ? 0 : i + 1;
			ex = coord(sx, j) - coord(sx, i);
			ey = coord(sy, j) - coord(sy, i);
			proj(p.ax, p.ay, na, -ey, ex, alo, ahi);
			proj(p.bx, p.by, nb, -ey, ex, blo, bhi);
			if (ahi < blo || bhi < alo) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic polygons_overlap(poly_pair_t p);
		return !(edge_separates(p, 1'b0) || edge_separates(p, 1'b1));
	endfunction

	// pack four 16-bit lanes; upper lane bits beyond CB are ignored by the block
	function automatic logic [63:0] lanes(int v0, int v1, int v2, int v3);
		return {v3[15:0], v2[15:0], v1[15:0], v0[15:0]};
	endfunction

	function automatic poly_pair_t shape_pair(int cx, int cy, int r, int dx, int dy);
		poly_pair_t p;
		int rb;
		rb = $urandom_range(1, r);
		p.ax = lanes(cx - r, cx + r, cx + r, cx - r);
		p.ay = lanes(cy - r, cy - r, cy + r, cy + r);
		p.bx = lanes(cx + dx, cx + dx + rb, cx + dx, cx + dx - rb);
		p.by = lanes(cy + dy - rb, cy + dy, cy + dy + rb, cy + dy);
		p.ac = 3'($urandom_range(3, 4));
		p.bc = 3'($urandom_range(3, 4));
		p.hold = 1'b0;
		return p;
	endfunction

	// append one pair to the pending list
	task automatic enqueue_pair(poly_pair_t p);
		pending_pairs.insert(pending_pairs.size(), p);
	endtask

	// stimulus
	initial begin
		poly_pair_t p;
		int r;
		// directed: squares/diamonds near, touching and apart
		p = shape_pair(0, 0, 10, 0, 0); p.ac = 3'd4; p.bc = 3'd4; enqueue_pair(p);
		p = shape_pair(0, 0, 10, 100, 0); enqueue_pair(p);
		p.ax = lanes(0, 10, 10, 0); p.ay = lanes(0, 0, 10, 10);
		p.bx = lanes(10, 20, 20, 10); p.by = lanes(0, 0, 10, 10);
		p.ac = 3'd4; p.bc = 3'd4; enqueue_pair(p); // touching edge
		p.bx = lanes(11, 20, 20, 11); enqueue_pair(p); // just apart
		// extreme coordinates
		p.ax = lanes(-32768, 32767, 32767, -32768); p.ay = lanes(-32768, -32768, 32767, 32767);
		p.bx = lanes(32767, 32767, 32767, 32767); p.by = lanes(32767, 32767, 32767, 32767);
		enqueue_pair(p); // zero-length edges in B
		p.bx = '1; p.by = '0; p.ax = '0; p.ay = '1; enqueue_pair(p);
		p.ax = {4{16'h8000}}; p.ay = {4{16'h7fff}}; p.bx = {4{16'h7fff}}; p.by = {4{16'h8000}};
		enqueue_pair(p);
		// out-of-range counts
		for (int c = 0; c < 8; c++) begin
			p = shape_pair(0, 0, 50, 60, 60);
			p.ax[63:48] = 16'h9000; // fourth vertex matters only when count >= 4
			p.ac = 3'(c); p.bc = 3'(7 - c);
			enqueue_pair(p);
		end
		// non-convex bow-tie against a small triangle
		p.ax = lanes(0, 100, 0, 100); p.ay = lanes(0, 100, 100, 0);
		p.bx = lanes(40, 60, 50, 0); p.by = lanes(45, 45, 55, 0);
		p.ac = 3'd4; p.bc = 3'd3; enqueue_pair(p);
		// random: mostly shapes near each other, some pure noise
		for (int n = 0; n < 1800; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				p.ax = {$urandom, $urandom}; p.ay = {$urandom, $urandom};
				p.bx = {$urandom, $urandom}; p.by = {$urandom, $urandom};
				p.ac = 3'($urandom); p.bc = 3'($urandom); p.hold = 1'b0;
			end else begin
				r = $urandom_range(0, 3) == 0 ? $urandom_range(1000, 12000) : $urandom_range(1, 60);
				p = shape_pair(int'($urandom_range(0, 16000)) - 8000,
					int'($urandom_range(0, 16000)) - 8000, r,
					int'($urandom_range(0, 6 * r)) - 3 * r,
					int'($urandom_range(0, 6 * r)) - 3 * r);
				if ($urandom_range(0, 1)) p.ax = {$urandom, p.ax[31:0]};
				if ($urandom_range(0, 1)) p.by = {$urandom, p.by[31:0]};
			end
			p.hold = (n == 900);
			enqueue_pair(p);
		end
		stimulus_done = 1'b1;
	end

	// driver
	int gap_left = 0;
	initial begin
		#(90);
		@(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		poly_pair_t p;
		if (arst_n) begin
			if (start && !busy) begin
				overlap_expected.insert(overlap_expected.size(),
					polygons_overlap('{poly_a_x, poly_a_y, poly_b_x,
					poly_b_y, poly_a_count, poly_b_count, 1'b0}));
				gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4);
			end
			if (start && !busy && gap_left > 0 || !(start && !busy) && !start && gap_left > 0) begin
				start <= 1'b0;
				gap_left = gap_left - 1;
			end else if (start && busy) begin
				start <= 1'b1; // hold the item until taken
			end else if (pending_pairs.size() > 0 &&
					!(pending_pairs[0].hold && overlap_expected.size() > 0)) begin
				p = pending_pairs.pop_front();
				poly_a_x <= p.ax; poly_a_y <= p.ay; poly_a_count <= p.ac;
				poly_b_x <= p.bx; poly_b_y <= p.by; poly_b_count <= p.bc;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		logic exp_ov;
		if (arst_n && done) begin
			if (overlap_expected.size() == 0) begin
				$error("overlap: result with no transaction pending, actual %0b", overlap);
				failures++;
			end else begin
				exp_ov = overlap_expected.pop_front();
				if (overlap !== exp_ov) begin
					$error("overlap: expected %0b actual %0b", exp_ov, overlap);
					failures++;
				end
			end
		end
	end

	// watchdog and end of run
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((start && !busy) || done) quiet_cycles = 0;
			else quiet_cycles++;
			if (stimulus_done && pending_pairs.size() == 0 && !start
					&& overlap_expected.size() == 0) begin
				repeat (LATENCY + 5) @(posedge clk);
				if (failures == 0 && overlap_expected.size() == 0)
					$display("status: pass");
				else
					$display("status: fail");
				$finish;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule
